>>> design/dsr_pkg.sv
`timescale 1ns / 1ps
// dsr_pkg: constants, command and status codes for the data stack
// no dependencies; used by the interfaces, the top level and the checker
package dsr_pkg;

	localparam int DEPTH     = 256;
	localparam int WORD_BITS = 32;

	// fixed field widths of the request and response
	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = 8;
	localparam int COUNT_W = 9;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	// compare width: wide enough for index plus three and for the count
	localparam int CMP_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

	localparam int CACHE_N = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 3'd0,
		CMD_POP  = 3'd1,
		CMD_DUP  = 3'd2,
		CMD_SWAP = 3'd3,
		CMD_ROT  = 3'd4,
		CMD_PEEK = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

>>> design/dsr_if.sv
`timescale 1ns / 1ps
// dsr_req_if and dsr_rsp_if: valid/ready channels for commands and results
// depends on dsr_pkg for field widths
interface dsr_req_if;
	logic                        valid;
	logic                        ready;
	logic [dsr_pkg::CMD_W-1:0]   cmd;
	logic [dsr_pkg::VALUE_W-1:0] push_value;
	logic [dsr_pkg::IDX_W-1:0]   peek_index;

	modport source (output valid, output cmd, output push_value, output peek_index,
		input ready);
	modport sink (input valid, input cmd, input push_value, input peek_index,
		output ready);
endinterface

interface dsr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [dsr_pkg::VALUE_W-1:0] read_value;
	logic [1:0]                  status;
	logic [dsr_pkg::COUNT_W-1:0] count;

	modport source (output valid, output read_value, output status, output count,
		input ready);
	modport sink (input valid, input read_value, input status, input count,
		output ready);
endinterface

>>> design/dsr_ram.sv
`timescale 1ns / 1ps
// dsr_ram: generic single write port, single read port synchronous ram
// read data registered; no dependencies
module dsr_ram #(
	parameter int DEPTH_P = 256,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_P)-1:0] waddr,
	input  logic [WIDTH_P-1:0]         wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem_q [DEPTH_P];
	logic [WIDTH_P-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/data_stack_with_dup_swap_rot.sv
`timescale 1ns / 1ps
// data_stack_with_dup_swap_rot: bounded lifo stack with push, pop, dup, swap, rot, peek
// depends on dsr_pkg, dsr_if (dsr_req_if, dsr_rsp_if) and dsr_ram
//
//   channel  dir  fields                           moves on
//   req      in   cmd, push_value, peek_index      valid && ready
//   rsp      out  read_value, status, count        valid && ready
//
// each request takes the ram read first, then the execute step, which updates the top-three
// register cache, writes back the entry pushed out of it and loads the result.
// the ram has one read and one write port; the next request is taken only
// after the current one has left the execute stage.
// reset clears the count and control; ram contents stay undefined, no sweep.
// a stalled result holds in the output register; one more request may be
// taken meanwhile and waits in the execute stage.
module data_stack_with_dup_swap_rot (
	input  logic       clk,
	input  logic       arst_n,
	dsr_req_if.sink    req,
	dsr_rsp_if.source  rsp
);
	import dsr_pkg::*;

	// execute stage
	logic                 s1_valid_q;
	cmd_t                 cmd_s1;
	logic [WORD_BITS-1:0] value_s1;
	logic [IDX_W-1:0]     index_s1;

	// architectural state kept in registers: count and the top three words
	logic [CNT_W-1:0]     count_q;
	logic [WORD_BITS-1:0] cache_q [CACHE_N];

	// output register
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   read_value_q;
	status_t              status_q;
	logic [COUNT_W-1:0]   count_out_q;

	logic                 req_fire;
	logic                 exec;
	logic [ADDR_W-1:0]    raddr;
	logic [WORD_BITS-1:0] rdata;

	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [CNT_W-1:0]     nxt_count;
	logic [WORD_BITS-1:0] nxt_cache [CACHE_N];
	logic [WORD_BITS-1:0] rd_word;
	status_t              st;
	logic [CMP_W-1:0]     n_cmp;
	logic [CMP_W-1:0]     idx_cmp;
	logic [CMP_W-1:0]     pos;
	logic                 full;
	logic                 spill;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = !s1_valid_q;
	assign exec      = s1_valid_q && (!out_valid_q || rsp.ready);

	// pop refills the cache from the entry below the top three
	assign raddr = (req.cmd == CMD_POP) ? ADDR_W'(count_q - CNT_W'(4))
	                                    : ADDR_W'(req.peek_index);

	dsr_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cache_q[2]),
		.re    (req_fire),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1   <= cmd_t'(req.cmd);
			value_s1 <= WORD_BITS'(req.push_value);
			index_s1 <= req.peek_index;
		end
	end

	assign n_cmp   = CMP_W'(count_q);
	assign idx_cmp = CMP_W'(index_s1);
	assign pos     = n_cmp - idx_cmp - CMP_W'(1);
	assign full    = (count_q >= CNT_W'(DEPTH));
	assign spill   = (count_q >= CNT_W'(CACHE_N));
	assign waddr   = ADDR_W'(count_q - CNT_W'(CACHE_N));

	always_comb begin
		nxt_count = count_q;
		for (int i = 0; i < CACHE_N; i++) begin
			nxt_cache[i] = cache_q[i];
		end
		rd_word = '0;
		st      = ST_OK;
		we      = 1'b0;
		unique case (cmd_s1)
			CMD_PUSH: begin
				if (full) begin
					st = ST_OVER;
				end else begin
					we           = exec && spill;
					nxt_cache[0] = value_s1;
					nxt_cache[1] = cache_q[0];
					nxt_cache[2] = cache_q[1];
					nxt_count    = CNT_W'(count_q + 1'b1);
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					st = ST_UNDER;
				end else begin
					rd_word      = cache_q[0];
					nxt_cache[0] = cache_q[1];
					nxt_cache[1] = cache_q[2];
					nxt_cache[2] = rdata;
					nxt_count    = CNT_W'(count_q - 1'b1);
				end
			end
			CMD_DUP: begin
				if (count_q == '0) begin
					st = ST_UNDER;
				end else if (full) begin
					st = ST_OVER;
				end else begin
					we           = exec && spill;
					nxt_cache[1] = cache_q[0];
					nxt_cache[2] = cache_q[1];
					nxt_count    = CNT_W'(count_q + 1'b1);
				end
			end
			CMD_SWAP: begin
				if (count_q < CNT_W'(2)) begin
					st = ST_UNDER;
				end else begin
					nxt_cache[0] = cache_q[1];
					nxt_cache[1] = cache_q[0];
				end
			end
			CMD_ROT: begin
				if (count_q < CNT_W'(3)) begin
					st = ST_UNDER;
				end else begin
					// third from top moves up
					nxt_cache[0] = cache_q[2];
					nxt_cache[1] = cache_q[0];
					nxt_cache[2] = cache_q[1];
				end
			end
			CMD_PEEK: begin
				if (idx_cmp >= n_cmp) begin
					st = ST_RANGE;
				end else if (idx_cmp + CMP_W'(CACHE_N) >= n_cmp) begin
					rd_word = cache_q[pos[1:0]];
				end else begin
					rd_word = rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req_fire) begin
				s1_valid_q <= 1'b1;
			end else if (exec) begin
				s1_valid_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				count_q     <= nxt_count;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			for (int i = 0; i < CACHE_N; i++) begin
				cache_q[i] <= nxt_cache[i];
			end
			read_value_q <= VALUE_W'(rd_word);
			status_q     <= st;
			count_out_q  <= COUNT_W'(nxt_count);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_out_q;

endmodule

>>> design/dsr_checker.sv
`timescale 1ns / 1ps
// dsr_checker: port-level assertions for the data stack, bound to the top level
// depends on dsr_pkg and data_stack_with_dup_swap_rot
module dsr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [dsr_pkg::VALUE_W-1:0] rsp_read_value,
	input logic [1:0]                  rsp_status,
	input logic [dsr_pkg::COUNT_W-1:0] rsp_count
);
	import dsr_pkg::*;

	// one request at a time in execute
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one still executing");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_count <= COUNT_W'(DEPTH)))
		else $error("reported count above stack depth");

	// failed commands read nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_value == '0))
		else $error("non-zero read value on failed request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value)
			&& $stable(rsp_status) && $stable(rsp_count)))
		else $error("stalled result changed");

endmodule

bind data_stack_with_dup_swap_rot dsr_checker u_dsr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_status     (rsp.status),
	.rsp_count      (rsp.count)
);
